@@ hw/rtl/sess_tbl_pkg.sv @@
// Shared widths, field positions and request codes for the session table.
`default_nettype none

package sess_tbl_pkg;

    localparam int NODE_ADDR_W   = 40;
    localparam int SESSION_W     = 32;
    localparam int SLOT_W        = 3;

    localparam int IN_TDATA_W    = 72;
    localparam int OUT_TDATA_W   = 40;
    localparam int OUT_USED_W    = SLOT_W + SESSION_W;

    typedef enum logic
    {
        REQ_LOOKUP = 1'b0,
        REQ_SAVE   = 1'b1
    } req_type_t;

endpackage

`default_nettype wire

@@ hw/rtl/session_table_by_address_core.sv @@
// Session table keyed by peer address, with lookup and save over a stream interface.
`default_nettype none

// The block keeps ENTRIES pairs of peer address and session id, all zero after reset.
// A request transfer is first captured in an input register. When the output is not
// stalled, one pass of logic compares the address with every entry, finds the first entry
// that holds the smallest id, updates the table on a save and loads the result register.
// One request completes per cycle while the output is not stalled. The next request sees
// the table as the previous request left it. The rate is set by that single pass
// of logic from the input register through the table update.
module session_table_by_address_core
    import sess_tbl_pkg::*;
#(
    parameter int ENTRIES   = 8,
    parameter int ADDR_BITS = 40
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata: node_address [39:0], session_value [71:40]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: req_type
    input  wire logic                   s_axis_tuser,

    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // tdata: slot [2:0], stored_id [34:3], zero [39:35]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // tuser: hit
    output logic                        m_axis_tuser
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic                   in_valid_reg;
    logic                   in_save_reg;
    logic [ADDR_BITS-1:0]   in_addr_reg;
    logic [SESSION_W-1:0]   in_value_reg;

    logic                   out_valid_reg;
    logic                   out_hit_reg;
    logic [SLOT_W-1:0]      out_slot_reg;
    logic [SESSION_W-1:0]   out_id_reg;

    logic [ADDR_BITS-1:0]   entry_addr_reg [ENTRIES];
    logic [SESSION_W-1:0]   entry_id_reg   [ENTRIES];

    logic                   out_free;
    logic                   advance;
    logic [ENTRIES-1:0]     match_vec;
    logic                   match_found;
    logic [IDX_W-1:0]       match_idx;
    logic [IDX_W-1:0]       victim_idx;
    logic [SESSION_W-1:0]   least_id;
    logic [IDX_W-1:0]       sel_idx;
    logic                   read_used;
    logic [SESSION_W-1:0]   sel_id;
    logic                   out_hit_next;
    logic [SLOT_W-1:0]      out_slot_next;
    logic [SESSION_W-1:0]   out_id_next;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_vec[i] = (entry_addr_reg[i] == in_addr_reg);
        end
        match_found = |match_vec;

        match_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                match_idx = IDX_W'(i);
            end
        end

        least_id   = entry_id_reg[0];
        victim_idx = '0;
        for (int i = 1; i < ENTRIES; i++)
        begin
            if (entry_id_reg[i] < least_id)
            begin
                least_id   = entry_id_reg[i];
                victim_idx = IDX_W'(i);
            end
        end

        if (match_found)
        begin
            sel_idx = match_idx;
        end
        else if (in_save_reg)
        begin
            sel_idx = victim_idx;
        end
        else
        begin
            sel_idx = '0;
        end

        read_used     = match_found || in_save_reg;
        sel_id        = entry_id_reg[sel_idx];
        out_hit_next  = match_found;
        out_slot_next = read_used ? SLOT_W'(sel_idx) : '0;
        out_id_next   = read_used ? sel_id : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_save_reg  <= (s_axis_tuser == REQ_SAVE);
            in_addr_reg  <= ADDR_BITS'(s_axis_tdata[NODE_ADDR_W-1:0]);
            in_value_reg <= s_axis_tdata[NODE_ADDR_W +: SESSION_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_hit_reg  <= out_hit_next;
            out_slot_reg <= out_slot_next;
            out_id_reg   <= out_id_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                entry_addr_reg[i] <= '0;
                entry_id_reg[i]   <= '0;
            end
        end
        else if (advance && in_save_reg)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (sel_idx == IDX_W'(i))
                begin
                    entry_id_reg[i] <= in_value_reg;
                    if (!match_found)
                    begin
                        entry_addr_reg[i] <= in_addr_reg;
                    end
                end
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_hit_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({out_id_reg, out_slot_reg});

endmodule

`default_nettype wire

@@ hw/rtl/sess_tbl_checker.sv @@
// Port-level checks for the session table core and the bind that attaches them.
`default_nettype none

module sess_tbl_checker
    import sess_tbl_pkg::*;
#(
    parameter int ENTRIES = 8
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    input  wire logic                   s_axis_tready,
    input  wire logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire logic                   m_axis_tuser
);

    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_xfer && !out_xfer)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (out_xfer && !in_xfer)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // Every result transfer is backed by an earlier request transfer.
    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> pending_reg != 2'd0)
        else $error("result offered with no request outstanding");

    // At most one request in the input stage and one result in the output stage.
    a_bounded_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more requests held than the core has stages");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[SLOT_W-1:0] < SLOT_W'(ENTRIES - 1) + SLOT_W'(1)
            || ENTRIES > 7)
        else $error("slot outside the table");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:OUT_USED_W] == '0)
        else $error("padding bits of the result are not zero");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind session_table_by_address_core sess_tbl_checker #(
    .ENTRIES (ENTRIES)
) u_sess_tbl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ bench/session_table_by_address_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking stream testbench for the session table core, with its own table predictor.

module session_table_by_address_core_tb;

    import sess_tbl_pkg::*;

    localparam int TABLE_DEPTH = 8;
    localparam int ADDR_POOL   = 12;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_PRINTS  = 40;
    localparam logic [SESSION_W-1:0] ID_MAX = 32'hFFFF_FFFF;

    typedef struct packed
    {
        req_type_t              kind;
        logic [NODE_ADDR_W-1:0] addr;
        logic [SESSION_W-1:0]   sid;
    } request_t;

    typedef struct packed
    {
        logic                 hit;
        logic [SLOT_W-1:0]    slot;
        logic [SESSION_W-1:0] stored_id;
    } table_reply_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = REQ_LOOKUP;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    request_t               pending_requests[$];
    table_reply_t           expected_replies[$];
    logic [NODE_ADDR_W-1:0] addr_tab[TABLE_DEPTH];
    logic [SESSION_W-1:0]   id_tab[TABLE_DEPTH];
    logic [NODE_ADDR_W-1:0] addr_pool[ADDR_POOL];

    bit in_took = 1'b0;
    int idle_pct = 0;
    int tx_gap = 0;
    int rx_gap = 0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_cnt = 0;
    int mismatches = 0;

    session_table_by_address_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("session_table_by_address_core_tb NOT OK");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            addr_tab[i] = '0;
            id_tab[i]   = '0;
        end
    end

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("mismatch at %0t: %s got %h, expected %h", $realtime, what, got, want);
    endtask

    function automatic table_reply_t apply_request(request_t rq);
        table_reply_t r;
        int match;
        int idx;
        logic [SESSION_W-1:0] least;
        bit found_free;
        r = '0;
        match = -1;
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (match < 0 && addr_tab[i] == rq.addr)
                match = i;
        if (rq.kind == REQ_LOOKUP)
        begin
            if (match >= 0)
            begin
                r.hit       = 1'b1;
                r.slot      = SLOT_W'(match);
                r.stored_id = id_tab[match];
            end
        end
        else
        begin
            if (match >= 0)
            begin
                idx   = match;
                r.hit = 1'b1;
            end
            else
            begin
                idx = 0;
                least = ID_MAX;
                found_free = 1'b0;
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (!found_free)
                    begin
                        if (id_tab[i] == '0)
                        begin
                            idx = i;
                            found_free = 1'b1;
                        end
                        else if (id_tab[i] < least)
                        begin
                            least = id_tab[i];
                            idx = i;
                        end
                    end
                end
                addr_tab[idx] = rq.addr;
            end
            r.slot      = SLOT_W'(idx);
            r.stored_id = id_tab[idx];
            id_tab[idx] = rq.sid;
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        request_t rq;
        table_reply_t want;
        in_took = s_axis_tvalid && s_axis_tready;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_replies.size() == 0)
                flag_mismatch("result with nothing pending", 64'(m_axis_tdata), 64'd0);
            else
            begin
                want = expected_replies.pop_front();
                if (m_axis_tuser !== want.hit)
                    flag_mismatch("hit", 64'(m_axis_tuser), 64'(want.hit));
                if (m_axis_tdata[SLOT_W-1:0] !== want.slot)
                    flag_mismatch("slot", 64'(m_axis_tdata[SLOT_W-1:0]), 64'(want.slot));
                if (m_axis_tdata[OUT_USED_W-1:SLOT_W] !== want.stored_id)
                    flag_mismatch("stored_id", 64'(m_axis_tdata[OUT_USED_W-1:SLOT_W]),
                                  64'(want.stored_id));
                if (m_axis_tdata[OUT_TDATA_W-1:OUT_USED_W] !== '0)
                    flag_mismatch("padding", 64'(m_axis_tdata[OUT_TDATA_W-1:OUT_USED_W]),
                                  64'd0);
            end
        end
        if (rst_n && in_took)
        begin
            rq.kind = req_type_t'(s_axis_tuser);
            rq.addr = s_axis_tdata[NODE_ADDR_W-1:0];
            rq.sid  = s_axis_tdata[IN_TDATA_W-1:NODE_ADDR_W];
            expected_replies.push_back(apply_request(rq));
        end
    end

    always @(negedge clk)
    begin
        request_t rq;
        if (rst_n && (!s_axis_tvalid || in_took))
        begin
            if (tx_gap > 0)
            begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            begin
                tx_gap = $urandom_range(1, 8) - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_requests.size() > 0)
            begin
                rq = pending_requests.pop_front();
                s_axis_tdata  <= {rq.sid, rq.addr};
                s_axis_tuser  <= rq.kind;
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_req && !hold_done)
        begin
            hold_cnt++;
            if (hold_cnt >= HOLD_CYCLES)
                hold_done = 1'b1;
            m_axis_tready <= 1'b0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            m_axis_tready <= 1'b0;
        end
        else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            rx_gap = $urandom_range(1, 8) - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    task automatic queue_request(input req_type_t kind, input logic [NODE_ADDR_W-1:0] addr,
                                 input logic [SESSION_W-1:0] sid);
        request_t rq;
        rq.kind = kind;
        rq.addr = addr;
        rq.sid  = sid;
        pending_requests.push_back(rq);
    endtask

    function automatic logic [NODE_ADDR_W-1:0] random_address();
        return NODE_ADDR_W'({$urandom, $urandom});
    endfunction

    task automatic queue_random(input int count);
        logic [NODE_ADDR_W-1:0] addr;
        logic [SESSION_W-1:0] sid;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 5)
                addr_pool[$urandom_range(0, ADDR_POOL - 1)] = random_address();
            pick = $urandom_range(0, 99);
            if (pick < 70)
                addr = addr_pool[$urandom_range(0, ADDR_POOL - 1)];
            else if (pick < 80)
                addr = '0;
            else
                addr = random_address();
            pick = $urandom_range(0, 99);
            if (pick < 10)
                sid = '0;
            else if (pick < 20)
                sid = ID_MAX;
            else if (pick < 45)
                sid = SESSION_W'($urandom_range(1, 4));
            else
                sid = $urandom;
            queue_request($urandom_range(0, 1) ? REQ_SAVE : REQ_LOOKUP, addr, sid);
        end
    endtask

    task automatic drain();
        while (pending_requests.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_replies.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        for (int i = 0; i < ADDR_POOL; i++)
            addr_pool[i] = random_address();
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        idle_pct = 20;
        queue_request(REQ_LOOKUP, '0, ID_MAX);
        queue_request(REQ_LOOKUP, '1, '0);
        queue_request(REQ_SAVE, '1, ID_MAX);
        for (int k = 1; k < TABLE_DEPTH; k++)
            queue_request(REQ_SAVE, 40'h1 << (k * 5), ID_MAX);
        queue_request(REQ_SAVE, 40'h00_0000_0C3A, 32'd7);
        queue_request(REQ_LOOKUP, '1, '0);
        queue_request(REQ_SAVE, 40'h1 << 15, '0);
        queue_request(REQ_SAVE, 40'hA5_A5A5_A5A5, 32'd9);
        queue_request(REQ_LOOKUP, 40'hA5_A5A5_A5A5, '0);
        queue_request(REQ_SAVE, '0, 32'd1);
        queue_request(REQ_LOOKUP, '0, 32'h5A5A_5A5A);
        queue_request(REQ_SAVE, 40'hA5_A5A5_A5A5, 32'd1);
        queue_request(REQ_SAVE, 40'h12_3456_789A, 32'd2);
        queue_request(REQ_SAVE, 40'h12_3456_789A, ID_MAX);
        queue_request(REQ_LOOKUP, 40'h1 << 35, '0);
        drain();

        idle_pct = 25;
        queue_random(600);
        drain();

        idle_pct = 0;
        hold_req = 1'b1;
        queue_random(200);
        drain();

        idle_pct = 30;
        queue_random(600);
        drain();

        idle_pct = 0;
        queue_random(530);
        drain();
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("session_table_by_address_core_tb OK");
        else
            $display("session_table_by_address_core_tb NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/sess_tbl_pkg.sv
hw/rtl/session_table_by_address_core.sv
hw/rtl/sess_tbl_checker.sv
bench/session_table_by_address_core_tb.sv
